@@ hw/rtl/cclp_pkg.sv @@
// shared types and constants for the command line parser
`default_nettype none
package cclp_pkg;

  localparam int unsigned NumWords = 9;
  localparam logic [NumWords-1:0] AllWords = '1;

  typedef enum logic [3:0] {
    MSG_NONE     = 4'd0,
    MSG_LIST     = 4'd1,
    MSG_NEW      = 4'd2,
    MSG_SELECT   = 4'd3,
    MSG_WEIGHT   = 4'd4,
    MSG_AGE      = 4'd5,
    MSG_DISCH    = 4'd6,
    MSG_KANGAROO = 4'd7,
    MSG_HISTORY  = 4'd8,
    MSG_WHISTORY = 4'd9
  } msg_type_e;

  localparam logic [7:0] CharComma = 8'h2C;

  // keyword length per command word
  function automatic logic [4:0] word_len(input logic [3:0] k);
    logic [4:0] r;
    case (k)
      4'd0: r = 5'd16;
      4'd1: r = 5'd11;
      4'd2: r = 5'd14;
      4'd3: r = 5'd14;
      4'd4: r = 5'd18;
      4'd5: r = 5'd17;
      4'd6: r = 5'd16;
      4'd7: r = 5'd19;
      4'd8: r = 5'd18;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // field count required per command word
  function automatic logic [3:0] word_fields(input logic [3:0] k);
    logic [3:0] r;
    case (k)
      4'd0: r = 4'd2;
      4'd1: r = 4'd4;
      4'd2: r = 4'd3;
      4'd3: r = 4'd4;
      4'd4: r = 4'd4;
      4'd5: r = 4'd4;
      4'd6: r = 4'd3;
      4'd7: r = 4'd3;
      4'd8: r = 4'd3;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // character of command word k at position p, zero past its end
  function automatic logic [7:0] word_char(input logic [3:0] k, input logic [4:0] p);
    logic [8*19-1:0] s;
    logic [7:0] r;
    case (k)
      4'd0: s = {"PROFILE_", "LIST_REQ", 24'h0};
      4'd1: s = {"PROFILE_", "NEW", 64'h0};
      4'd2: s = {"PROFILE_", "SELECT", 40'h0};
      4'd3: s = {"PROFILE_", "WEIGHT", 40'h0};
      4'd4: s = {"PROFILE_", "AGE_MANUAL", 8'h0};
      4'd5: s = {"PROFILE_", "DISCHARGE", 16'h0};
      4'd6: s = {"PROFILE_", "KANGAROO", 24'h0};
      4'd7: s = {"PROFILE_", "HISTORY_REQ"};
      4'd8: s = {"WEIGHT_", "HISTORY_REQ", 8'h0};
      default: s = '0;
    endcase
    if (p < 5'd19) r = s[8*(18 - 32'(p)) +: 8];
    else r = 8'h0;
    return r;
  endfunction

  typedef struct packed {
    logic [3:0] msg_type;
    logic [31:0] seq;
    logic [15:0] arg;
    logic [4:0] nlen;
  } rec_t;

endpackage
`default_nettype wire

@@ hw/rtl/cclp_decide.sv @@
// end-of-line decision: command selection and per-command limits
`default_nettype none
module cclp_decide #(
  parameter int unsigned NameCap = 31,
  parameter int unsigned MaxOutcome = 3
) (
  input  wire logic [3:0]  field_index_i,
  input  wire logic        line_error_i,
  input  wire logic [8:0]  cand_i,
  input  wire logic [32:0] num1_i,
  input  wire logic [16:0] num2_i,
  input  wire logic [2:0]  flags_i,
  input  wire logic [5:0]  len2_i,
  input  wire logic [5:0]  len3_i,
  output cclp_pkg::rec_t   rec_o
);
  import cclp_pkg::*;

  logic [3:0] cmd;
  logic found, ok2, ok3, skip;
  logic [3:0] nf;

  always_comb begin
    cmd = 4'd0;
    found = 1'b0;
    for (int k = 0; k < NumWords; k++) begin
      if (cand_i[k]) begin
        cmd = 4'(k);
        found = 1'b1;
      end
    end
  end

  assign nf = field_index_i + 4'd1;
  assign ok2 = !flags_i[0] && len2_i >= 6'd1 && len2_i <= 6'd10 && !num1_i[32];
  assign ok3 = !flags_i[1] && len3_i >= 6'd1 && len3_i <= 6'd10;
  assign skip = !flags_i[2] && len3_i == 6'd4;

  always_comb begin
    rec_o = '0;
    if (!line_error_i && field_index_i >= 4'd1 && found && nf == word_fields(cmd)) begin
      case (cmd)
        4'd0: rec_o.msg_type = MSG_LIST;
        4'd1: begin
          if (len2_i >= 6'd1 && 32'(len2_i) <= NameCap && ok3 && num2_i <= 17'd255) begin
            rec_o.msg_type = MSG_NEW;
            rec_o.arg = num2_i[15:0];
            rec_o.nlen = len2_i[4:0];
          end
        end
        4'd3: begin
          if (ok2 && skip) begin
            rec_o.msg_type = MSG_WEIGHT;
            rec_o.seq = num1_i[31:0];
          end else if (ok2 && ok3 && num2_i >= 17'd1 && num2_i <= 17'd65535) begin
            rec_o.msg_type = MSG_WEIGHT;
            rec_o.seq = num1_i[31:0];
            rec_o.arg = num2_i[15:0];
          end
        end
        4'd4: begin
          if (ok2 && ok3 && num2_i <= 17'd65535) begin
            rec_o.msg_type = MSG_AGE;
            rec_o.seq = num1_i[31:0];
            rec_o.arg = num2_i[15:0];
          end
        end
        4'd5: begin
          if (ok2 && ok3 && 32'(num2_i) <= MaxOutcome) begin
            rec_o.msg_type = MSG_DISCH;
            rec_o.seq = num1_i[31:0];
            rec_o.arg = num2_i[15:0];
          end
        end
        default: begin
          if (ok2) begin
            rec_o.msg_type = cmd + 4'd1;
            rec_o.seq = num1_i[31:0];
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/comma_command_line_parser.sv @@
// top level of the comma separated command line parser
// Input: one character per request (char_byte_i) or a line end marker
// (line_end_i), on a valid/ready channel. Zero bytes are dropped.
// Each character updates per-line state, so one request is accepted per
// cycle while no name results are queued and, for a line end, the output
// register is free or being drained. A line end request closes the line:
// in the next cycle the message record appears on the output channel; for
// a valid new-profile command it is followed by one result per name byte,
// read from a small name store. While those name results are sent (one per
// cycle when out_ready_i is high) the input is held off. last_of_run_o marks
// the final result. If the receiver stalls, the result stays in the output
// register and in_ready_o drops once a line end waits behind it; characters
// keep flowing unless name results are still queued.
// Reset clears all line state and empties the output register; the name
// store holds no reset value and is only read after this line wrote it.
`default_nettype none
module comma_command_line_parser #(
  parameter int unsigned NAME_LEN = 32,
  parameter int unsigned MAX_OUTCOME = 3
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  char_byte_i,
  input  wire logic        line_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       msg_type_o,
  output logic [31:0]      seq_or_page_o,
  output logic [15:0]      arg_value_o,
  output logic [4:0]       name_length_o,
  output logic             is_name_char_o,
  output logic [7:0]       name_char_o,
  output logic             last_of_run_o
);
  import cclp_pkg::*;

  localparam int unsigned NameCap = (NAME_LEN - 1) < 31 ? (NAME_LEN - 1) : 31;

  logic [3:0] fidx_q, fidx_d;
  logic [5:0] flen_q, flen_d;
  logic err_q, err_d;
  logic [8:0] cand_q, cand_d;
  logic [32:0] num1_q, num1_d;
  logic [16:0] num2_q, num2_d;
  logic [2:0] flags_q, flags_d;
  logic [5:0] len2_q, len2_d;
  logic [5:0] len3_q, len3_d;
  logic [7:0] name_mem [31];

  logic out_valid_q;
  rec_t rec_q;
  logic is_ch_q, last_q;
  logic [4:0] cnt_q;      // name results still to send after the current one
  logic [4:0] rd_q;       // next name index to send
  logic [7:0] ch_q;

  logic acc, is_char, is_comma, out_free, sending;
  logic [7:0] c;
  logic digit;
  logic [3:0] dval;
  rec_t rec_d;
  logic [3:0] fidx_c;
  logic [5:0] flen_c;
  logic [8:0] cand_c;

  assign sending = out_valid_q && cnt_q != 5'd0;
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = !sending && (!line_end_i || out_free);
  assign acc = in_valid_i && in_ready_o;
  assign c = char_byte_i;
  assign is_char = acc && !line_end_i && c != 8'h0;
  assign is_comma = c == CharComma;
  assign digit = c >= "0" && c <= "9";
  assign dval = 4'(c - "0");

  // closing the current field (at a comma or at line end)
  always_comb begin
    cand_c = cand_q;
    if (fidx_q == 4'd1) begin
      for (int k = 0; k < NumWords; k++) begin
        if ({1'b0, word_len(4'(k))} != flen_q) cand_c[k] = 1'b0;
      end
    end
  end
  assign fidx_c = fidx_q;
  assign flen_c = flen_q;

  always_comb begin
    fidx_d = fidx_q; flen_d = flen_q; err_d = err_q; cand_d = cand_q;
    num1_d = num1_q; num2_d = num2_q; flags_d = flags_q;
    len2_d = len2_q; len3_d = len3_q;
    if (acc && line_end_i) begin
      fidx_d = '0; flen_d = '0; err_d = 1'b0; cand_d = AllWords;
      num1_d = '0; num2_d = '0; flags_d = '0; len2_d = '0; len3_d = '0;
    end else if (is_char && is_comma) begin
      cand_d = cand_c;
      if (fidx_q == 4'd0 && flen_q != 6'd3) err_d = 1'b1;
      if (fidx_q == 4'd2) len2_d = flen_q;
      if (fidx_q == 4'd3) len3_d = flen_q;
      if (fidx_q >= 4'd7) err_d = 1'b1;
      else fidx_d = fidx_q + 4'd1;
      flen_d = '0;
    end else if (is_char) begin
      case (fidx_q)
        4'd0: begin
          if (flen_q >= 6'd3) err_d = 1'b1;
          else if (c != (flen_q == 6'd0 ? "H" : flen_q == 6'd1 ? "M" : "I")) err_d = 1'b1;
        end
        4'd1: begin
          for (int k = 0; k < NumWords; k++) begin
            if ({1'b0, word_len(4'(k))} <= flen_q
                || word_char(4'(k), flen_q[4:0]) != c) cand_d[k] = 1'b0;
          end
        end
        4'd2: begin
          if (!digit) flags_d[0] = 1'b1;
          else if (!num1_q[32]) begin
            if ((36'(num1_q) * 36'd10 + 36'(dval)) > 36'hFFFFFFFF) num1_d = 33'h100000000;
            else num1_d = 33'(num1_q * 33'd10 + 33'(dval));
          end
        end
        4'd3: begin
          if (!digit) flags_d[1] = 1'b1;
          else if (!num2_q[16]) begin
            if ((21'(num2_q) * 21'd10 + 21'(dval)) > 21'd65535) num2_d = 17'h10000;
            else num2_d = 17'(num2_q * 17'd10 + 17'(dval));
          end
          if (flen_q >= 6'd4) flags_d[2] = 1'b1;
          else if (c != (flen_q == 6'd0 ? "S" : flen_q == 6'd1 ? "K"
                         : flen_q == 6'd2 ? "I" : "P")) flags_d[2] = 1'b1;
        end
        default: ;
      endcase
      if (flen_q < 6'd63) flen_d = flen_q + 6'd1;
    end
  end

  // line end closes the last field in the same request
  logic [8:0] cand_e;
  logic err_e;
  logic [5:0] len2_e, len3_e;
  assign cand_e = cand_c;
  assign err_e = err_q || (fidx_c == 4'd0 && flen_c != 6'd3);
  assign len2_e = fidx_c == 4'd2 ? flen_c : len2_q;
  assign len3_e = fidx_c == 4'd3 ? flen_c : len3_q;

  cclp_decide #(
    .NameCap(NameCap),
    .MaxOutcome(MAX_OUTCOME)
  ) u_decide (
    .field_index_i(fidx_c),
    .line_error_i(err_e),
    .cand_i(cand_e),
    .num1_i(num1_q),
    .num2_i(num2_q),
    .flags_i(flags_q),
    .len2_i(len2_e),
    .len3_i(len3_e),
    .rec_o(rec_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fidx_q <= '0; flen_q <= '0; err_q <= 1'b0; cand_q <= AllWords;
      num1_q <= '0; num2_q <= '0; flags_q <= '0; len2_q <= '0; len3_q <= '0;
    end else begin
      fidx_q <= fidx_d; flen_q <= flen_d; err_q <= err_d; cand_q <= cand_d;
      num1_q <= num1_d; num2_q <= num2_d; flags_q <= flags_d;
      len2_q <= len2_d; len3_q <= len3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_char && !is_comma && fidx_q == 4'd2 && 32'(flen_q) < NameCap) begin
      name_mem[flen_q[4:0]] <= c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0; cnt_q <= '0; rd_q <= '0; is_ch_q <= 1'b0; last_q <= 1'b0;
    end else if (acc && line_end_i) begin
      out_valid_q <= 1'b1;
      is_ch_q <= 1'b0;
      rd_q <= '0;
      if (rec_d.msg_type == MSG_NEW) begin
        cnt_q <= rec_d.nlen; last_q <= 1'b0;
      end else begin
        cnt_q <= '0; last_q <= 1'b1;
      end
    end else if (out_valid_q && out_ready_i) begin
      if (cnt_q != 5'd0) begin
        is_ch_q <= 1'b1;
        cnt_q <= cnt_q - 5'd1;
        rd_q <= rd_q + 5'd1;
        last_q <= cnt_q == 5'd1;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && line_end_i) begin
      rec_q <= rec_d;
    end
    if (out_valid_q && out_ready_i && cnt_q != 5'd0) begin
      ch_q <= name_mem[rd_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign msg_type_o = rec_q.msg_type;
  assign seq_or_page_o = rec_q.seq;
  assign arg_value_o = rec_q.arg;
  assign name_length_o = rec_q.nlen;
  assign is_name_char_o = is_ch_q;
  assign name_char_o = is_ch_q ? ch_q : 8'h0;
  assign last_of_run_o = last_q;

  a_no_input_while_names: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sending |-> !in_ready_o) else $error("input taken during name results");
  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && last_q |-> cnt_q == 5'd0) else $error("last with names pending");
  a_name_only_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && is_ch_q |-> rec_q.msg_type == MSG_NEW) else $error("name on wrong type");

endmodule
`default_nettype wire

@@ dv/cclp_checker.sv @@
// checker for the command line parser: line predictor and result comparison
`timescale 1ns / 1ps
module cclp_checker
  import cclp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [7:0]  char_byte_i,
  input  wire logic        line_end_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [3:0]  msg_type_i,
  input  wire logic [31:0] seq_or_page_i,
  input  wire logic [15:0] arg_value_i,
  input  wire logic [4:0]  name_length_i,
  input  wire logic        is_name_char_i,
  input  wire logic [7:0]  name_char_i,
  input  wire logic        last_of_run_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               line_count_o
);
  localparam int NameCap = 31;

  typedef struct {
    logic [3:0]  mtype;
    logic [31:0] seq;
    logic [15:0] arg;
    logic [4:0]  nlen;
    logic        isch;
    logic [7:0]  ch;
    logic        last;
  } parse_res_t;

  parse_res_t expected_q[$];

  string word_str[9];
  int word_nf[9] = '{2, 4, 3, 4, 4, 4, 3, 3, 3};

  int          fidx, flen, len2, len3, nstored;
  bit          lerr;
  logic [8:0]  cand;
  logic [32:0] num1;
  logic [16:0] num2;
  logic [2:0]  flags;
  logic [7:0]  names[NameCap];

  function automatic void clear_line();
    fidx = 0; flen = 0; lerr = 0; cand = '1; num1 = 0; num2 = 0;
    flags = 0; nstored = 0; len2 = 0; len3 = 0;
  endfunction

  function automatic void close_field();
    if (fidx == 0) begin
      if (flen != 3) lerr = 1;
    end else if (fidx == 1) begin
      for (int k = 0; k < 9; k++) if (word_str[k].len() != flen) cand[k] = 0;
    end else if (fidx == 2) begin
      len2 = flen;
    end else if (fidx == 3) begin
      len3 = flen;
    end
  endfunction

  function automatic void take_char(logic [7:0] c);
    bit dig;
    string head;
    string skip_s;
    logic [63:0] wide;
    head = "HMI";
    skip_s = "SKIP";
    dig = c >= "0" && c <= "9";
    if (fidx == 0) begin
      if (flen >= 3 || head[flen] != c) lerr = 1;
    end else if (fidx == 1) begin
      for (int k = 0; k < 9; k++)
        if (flen >= word_str[k].len() || word_str[k][flen] != c) cand[k] = 0;
    end else if (fidx == 2) begin
      if (flen < NameCap) begin
        names[flen] = c;
        nstored = flen + 1;
      end
      if (!dig) flags[0] = 1;
      else if (num1 < 33'h1_0000_0000) begin
        wide = 64'(num1) * 64'd10 + 64'(c - "0");
        if (wide > 64'h0_FFFF_FFFF) num1 = 33'h1_0000_0000;
        else num1 = 33'(wide);
      end
    end else if (fidx == 3) begin
      if (!dig) flags[1] = 1;
      else if (num2 < 17'h10000) begin
        wide = 64'(num2) * 64'd10 + 64'(c - "0");
        if (wide > 64'hFFFF) num2 = 17'h10000;
        else num2 = 17'(wide);
      end
      if (flen >= 4 || skip_s[flen] != c) flags[2] = 1;
    end
    if (flen < 63) flen++;
  endfunction

  function automatic void finish_line();
    msg_type_e   t;
    logic [31:0] seq;
    logic [15:0] arg;
    int          cmd, nl;
    bit          ok2, ok3, skip;
    parse_res_t  r;
    t = MSG_NONE; seq = 0; arg = 0; nl = 0; cmd = 9;
    for (int k = 0; k < 9; k++) if (cand[k]) cmd = k;
    ok2 = !flags[0] && len2 >= 1 && len2 <= 10 && !num1[32];
    ok3 = !flags[1] && len3 >= 1 && len3 <= 10;
    skip = !flags[2] && len3 == 4;
    if (!lerr && fidx >= 1 && cmd < 9 && fidx + 1 == word_nf[cmd]) begin
      case (cmd)
        0: t = MSG_LIST;
        1: if (len2 >= 1 && len2 <= NameCap && ok3 && num2 <= 255) begin
          t = MSG_NEW; arg = num2[15:0]; nl = len2;
        end
        3: if (ok2 && skip) begin
          t = MSG_WEIGHT; seq = num1[31:0];
        end else if (ok2 && ok3 && num2 >= 1 && num2 <= 65535) begin
          t = MSG_WEIGHT; seq = num1[31:0]; arg = num2[15:0];
        end
        4: if (ok2 && ok3 && num2 <= 65535) begin
          t = MSG_AGE; seq = num1[31:0]; arg = num2[15:0];
        end
        5: if (ok2 && ok3 && num2 <= 3) begin
          t = MSG_DISCH; seq = num1[31:0]; arg = num2[15:0];
        end
        default: if (ok2) begin
          t = msg_type_e'(cmd + 1); seq = num1[31:0];
        end
      endcase
    end
    r = '{t, seq, arg, 5'(nl), 1'b0, 8'h0, 1'b0};
    r.last = (nl == 0);
    expected_q.push_back(r);
    for (int i = 0; i < nl; i++) begin
      r.isch = 1; r.ch = names[i]; r.last = (i + 1 == nl);
      expected_q.push_back(r);
    end
  endfunction

  function automatic void cmp(string f, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", f, e, a);
      fail_count_o++;
    end
  endfunction

  initial begin
    string pfx, wpfx;
    pfx = "PROFILE_";
    wpfx = "WEIGHT_";
    word_str[0] = {pfx, "LIST_REQ"};
    word_str[1] = {pfx, "NEW"};
    word_str[2] = {pfx, "SELECT"};
    word_str[3] = {pfx, "WEIGHT"};
    word_str[4] = {pfx, "AGE_MANUAL"};
    word_str[5] = {pfx, "DISCHARGE"};
    word_str[6] = {pfx, "KANGAROO"};
    word_str[7] = {pfx, "HISTORY_REQ"};
    word_str[8] = {wpfx, "HISTORY_REQ"};
    fail_count_o = 0;
    line_count_o = 0;
    clear_line();
  end

  assign pending_o = expected_q.size();

  always @(posedge clk_i) begin
    parse_res_t e;
    if (rst_ni && in_valid_i && in_ready_i) begin
      if (line_end_i) begin
        close_field();
        finish_line();
        clear_line();
        line_count_o++;
      end else if (char_byte_i == CharComma) begin
        close_field();
        if (fidx >= 7) lerr = 1;
        else fidx++;
        flen = 0;
      end else if (char_byte_i != 0) begin
        take_char(char_byte_i);
      end
    end
    if (rst_ni && out_valid_i && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("result with no expectation waiting");
        fail_count_o++;
      end else begin
        e = expected_q.pop_front();
        cmp("msg_type", 32'(e.mtype), 32'(msg_type_i));
        cmp("seq_or_page", e.seq, seq_or_page_i);
        cmp("arg_value", 32'(e.arg), 32'(arg_value_i));
        cmp("name_length", 32'(e.nlen), 32'(name_length_i));
        cmp("is_name_char", 32'(e.isch), 32'(is_name_char_i));
        cmp("name_char", 32'(e.ch), 32'(name_char_i));
        cmp("last_of_run", 32'(e.last), 32'(last_of_run_i));
      end
    end
  end
endmodule

@@ dv/testbench.sv @@
// testbench top: line stimulus for the command line parser and the verdict
`timescale 1ns / 1ps
module testbench;
  import cclp_pkg::*;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o, line_end_i;
  logic [7:0]  char_byte_i;
  logic        out_valid_o, out_ready_i;
  logic [3:0]  msg_type_o;
  logic [31:0] seq_or_page_o;
  logic [15:0] arg_value_o;
  logic [4:0]  name_length_o;
  logic        is_name_char_o, last_of_run_o;
  logic [7:0]  name_char_o;
  int          fail_count, pending, line_count, char_count;
  bit          drive_done;

  comma_command_line_parser u_top (.*);

  cclp_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .char_byte_i, .line_end_i,
    .out_valid_i(out_valid_o), .out_ready_i, .msg_type_i(msg_type_o),
    .seq_or_page_i(seq_or_page_o), .arg_value_i(arg_value_o),
    .name_length_i(name_length_o), .is_name_char_i(is_name_char_o),
    .name_char_i(name_char_o), .last_of_run_i(last_of_run_o),
    .fail_count_o(fail_count), .pending_o(pending), .line_count_o(line_count)
  );

  string words[9];
  int fields_of[9] = '{2, 4, 3, 4, 4, 4, 3, 3, 3};

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("comma_command_line_parser: mismatch");
    $finish;
  end

  // receiver stall pattern, some stretches with none
  initial begin
    int w;
    out_ready_i = 0;
    forever begin
      @(posedge clk_i);
      if (out_ready_i && out_valid_o) begin
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (w > 0) begin
          out_ready_i <= 0;
          repeat (w) @(posedge clk_i);
        end
        out_ready_i <= 1;
      end else begin
        out_ready_i <= 1;
      end
    end
  end

  task automatic send(logic [7:0] c, logic e);
    int g;
    g = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
    if (g > 0) begin
      in_valid_i <= 0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1;
    char_byte_i <= c;
    line_end_i <= e;
    do @(posedge clk_i); while (!in_ready_o);
    char_count++;
  endtask

  task automatic send_line(string s);
    for (int i = 0; i < s.len(); i++) send(s[i], 1'b0);
    send(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic string rnd_num(int kind);
    string s;
    case (kind)
      0: s = $sformatf("%0d", $urandom_range(0, 300));
      1: s = $sformatf("%0d", $urandom());
      2: s = "4294967296";
      3: s = "00000000001";
      4: s = "";
      default: s = $sformatf("%0d", $urandom_range(0, 70000));
    endcase
    return s;
  endfunction

  function automatic string rnd_text(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(1, 255)))};
    return s;
  endfunction

  function automatic string rnd_line();
    string s;
    int    k, nf;
    k = $urandom_range(0, 8);
    nf = fields_of[k];
    if ($urandom_range(0, 9) == 0) nf = $urandom_range(1, 9);
    s = ($urandom_range(0, 15) == 0) ? "HMJ" : "HMI";
    s = {s, ",", ($urandom_range(0, 15) == 0) ? {words[1], "X"} : words[k]};
    for (int f = 2; f < nf; f++) begin
      case ($urandom_range(0, 9))
        0: s = {s, ",", rnd_text($urandom_range(0, 5))};
        1: s = {s, ",SKIP"};
        2: if (k == 1) s = {s, ",", rnd_text($urandom_range(1, 35))};
           else s = {s, ",", rnd_num(2)};
        default: s = {s, ",", (k == 1 && f == 2) ? rnd_text($urandom_range(1, 31))
                                                 : rnd_num($urandom_range(0, 5))};
      endcase
    end
    if ($urandom_range(0, 15) == 0) s = {s, string'(8'h00)};
    return s;
  endfunction

  initial begin
    string s, pfx, wpfx;
    pfx = "PROFILE_";
    wpfx = "WEIGHT_";
    words[0] = {pfx, "LIST_REQ"};
    words[1] = {pfx, "NEW"};
    words[2] = {pfx, "SELECT"};
    words[3] = {pfx, "WEIGHT"};
    words[4] = {pfx, "AGE_MANUAL"};
    words[5] = {pfx, "DISCHARGE"};
    words[6] = {pfx, "KANGAROO"};
    words[7] = {pfx, "HISTORY_REQ"};
    words[8] = {wpfx, "HISTORY_REQ"};
    rst_ni = 0;
    in_valid_i = 0;
    char_byte_i = 0;
    line_end_i = 0;
    char_count = 0;
    drive_done = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: limits and special cases
    send_line("");
    send_line({"HMI,", words[1], ",AbcdefghijklmnopqrstuvwxyzABCDE,255"});
    send_line({"HMI,", words[1], ",x,256"});
    send_line({"HMI,", words[2], ",4294967296"});
    send_line({"HMI,", words[3], ",0,SKIP"});
    send_line({"HMI,", words[4], ",9999999999,65535"});
    send_line({"HMI,", words[5], ",3,4"});
    send_line({"HMI,", words[8], ",0"});
    send_line({"HMI,", words[0], ",,,,,,,"});
    s = {"HMI,", words[2], ",1"};
    s = {s, string'(8'h00), string'(8'hFF)};
    send_line(s);
    while (char_count < 300) send_line(rnd_line());
    in_valid_i <= 0;
    drive_done = 1;
  end

  initial begin
    wait (drive_done);
    @(posedge clk_i);
    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    $display("ran %0d lines in %0d requests: directed edge lines, then random lines",
             line_count, char_count);
    if (fail_count == 0 && pending == 0) $display("comma_command_line_parser: match");
    else $display("comma_command_line_parser: mismatch");
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/cclp_pkg.sv
hw/rtl/cclp_decide.sv
hw/rtl/comma_command_line_parser.sv
dv/cclp_checker.sv
dv/testbench.sv
